### rtl/fpa_pkg.sv
// Shared types and constants for the Q24.8 fixed-point ALU.
// Request and response payloads, operation codes, per-stage sideband.
// No dependencies.
`default_nettype none

package fpa_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS_DEF = 8;

    // operation codes carried in the kind field
    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;
    localparam logic [2:0] OP_MIN = 3'd4;
    localparam logic [2:0] OP_MAX = 3'd5;

    typedef struct packed {
        logic [2:0]               kind;
        logic signed [DATA_W-1:0] left_raw;
        logic signed [DATA_W-1:0] right_raw;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] result_raw;
        logic                     is_less;
        logic                     is_equal;
        logic                     is_greater;
        logic                     div_zero;
    } rsp_t;

    // sideband that rides along the divider chain with each request
    typedef struct packed {
        logic [2:0]        kind;
        logic [DATA_W-1:0] simple_res;  // add/sub/mul/min/max result
        logic              is_less;
        logic              is_equal;
        logic              is_greater;
        logic              div_zero;
        logic              quot_neg;    // operand signs differ
    } meta_t;

endpackage

`default_nettype wire

### rtl/fixed_point_q24_8_alu.sv
// Q24.8 fixed-point ALU: add, sub, mul, div, min, max with compare flags.
// Path: front stage register, one chain cell per quotient bit of the 32+FRAC_BITS bit
//   dividend, then the response register.
// Throughput: one request per cycle when not stalled; every stage stalls only when it is
//   full and the stage after it is stalled, so bubbles fill in behind a held response.
// Reset: rst_n clears all valid bits asynchronously; payload registers are not reset.
`default_nettype none

module fixed_point_q24_8_alu #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire           clk,
    input  wire           rst_n,
    input  wire           req_valid,
    output logic          req_ready,
    input  fpa_pkg::req_t req,
    output logic          rsp_valid,
    input  wire           rsp_ready,
    output fpa_pkg::rsp_t rsp
);

    localparam int W  = fpa_pkg::DATA_W;
    localparam int DW = W + FRAC_BITS;   // dividend width, also the number of cells

    // chain index 0 is the front stage output, index i+1 is cell i output
    logic           chain_valid [0:DW];
    logic           chain_ready [0:DW];
    fpa_pkg::meta_t chain_meta  [0:DW];
    logic [W-1:0]   chain_rem   [0:DW];
    logic [DW-1:0]  chain_dq    [0:DW];
    logic [W-1:0]   chain_dvs   [0:DW];

    // Front stage: compare flags and the add/sub/mul/min/max results are settled here,
    // the divider operands are turned into magnitudes.
    fpa_prep #(
        .FRAC_BITS (FRAC_BITS)
    ) u_prep (
        .clk        (clk),
        .rst_n      (rst_n),
        .up_valid   (req_valid),
        .up_ready   (req_ready),
        .up_req     (req),
        .down_valid (chain_valid[0]),
        .down_ready (chain_ready[0]),
        .down_meta  (chain_meta[0]),
        .down_rem   (chain_rem[0]),
        .down_dq    (chain_dq[0]),
        .down_dvs   (chain_dvs[0])
    );

    // Restoring divider, one quotient bit per cell, MSB first. Every request
    // walks the chain so results leave in order whatever the operation.
    for (genvar i = 0; i < DW; i++)
    begin : g_cell
        fpa_div_cell #(
            .FRAC_BITS (FRAC_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .up_valid   (chain_valid[i]),
            .up_ready   (chain_ready[i]),
            .up_meta    (chain_meta[i]),
            .up_rem     (chain_rem[i]),
            .up_dq      (chain_dq[i]),
            .up_dvs     (chain_dvs[i]),
            .down_valid (chain_valid[i+1]),
            .down_ready (chain_ready[i+1]),
            .down_meta  (chain_meta[i+1]),
            .down_rem   (chain_rem[i+1]),
            .down_dq    (chain_dq[i+1]),
            .down_dvs   (chain_dvs[i+1])
        );
    end

    // Output register: the quotient picks up its sign, divide by zero forces 0.
    fpa_finish #(
        .FRAC_BITS (FRAC_BITS)
    ) u_finish (
        .clk       (clk),
        .rst_n     (rst_n),
        .up_valid  (chain_valid[DW]),
        .up_ready  (chain_ready[DW]),
        .up_meta   (chain_meta[DW]),
        .up_dq     (chain_dq[DW]),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    // the final remainder and divisor are not needed past the last cell
    logic unused_tail;
    assign unused_tail = ^{chain_rem[DW], chain_dvs[DW]};

    // exactly one ordering flag per response
    a_flags_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> $onehot({rsp.is_less, rsp.is_equal, rsp.is_greater}))
        else $error("compare flags not one-hot");

    // a zero-divisor response carries a zero result
    a_div_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp.div_zero) |-> (rsp.result_raw == '0))
        else $error("divide by zero with nonzero result");

    // the request side only backs up when the response is held
    a_ready_when_drained: assert property (@(posedge clk) disable iff (!rst_n)
        (!rsp_valid || rsp_ready) |-> req_ready)
        else $error("request stalled while response side is free");

endmodule

`default_nettype wire

### rtl/fpa_prep.sv
// Front stage: compare flags, add/sub/mul/min/max, divider operand setup.
// Depends on fpa_pkg.
`default_nettype none

module fpa_prep #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire                                        clk,
    input  wire                                        rst_n,
    input  wire                                        up_valid,
    output logic                                       up_ready,
    input  fpa_pkg::req_t                              up_req,
    output logic                                       down_valid,
    input  wire                                        down_ready,
    output fpa_pkg::meta_t                             down_meta,
    output logic [fpa_pkg::DATA_W-1:0]                 down_rem,
    output logic [fpa_pkg::DATA_W+FRAC_BITS-1:0]       down_dq,
    output logic [fpa_pkg::DATA_W-1:0]                 down_dvs
);

    localparam int W  = fpa_pkg::DATA_W;
    localparam int DW = W + FRAC_BITS;

    logic                  valid_reg;
    fpa_pkg::meta_t        meta_reg, meta_next;
    logic [DW-1:0]         dq_reg, dq_next;
    logic [W-1:0]          dvs_reg, dvs_next;

    logic signed [W-1:0]   a, b;
    logic signed [2*W-1:0] prod;
    logic [W-1:0]          a_mag, b_mag;

    assign a    = up_req.left_raw;
    assign b    = up_req.right_raw;
    assign prod = a * b;

    always_comb
    begin
        a_mag = a[W-1] ? (~a + W'(1)) : a;
        b_mag = b[W-1] ? (~b + W'(1)) : b;

        meta_next.kind       = up_req.kind;
        meta_next.is_less    = (a < b);
        meta_next.is_equal   = (a == b);
        meta_next.is_greater = (a > b);
        meta_next.div_zero   = (up_req.kind == fpa_pkg::OP_DIV) && (b == '0);
        meta_next.quot_neg   = a[W-1] ^ b[W-1];

        case (up_req.kind)
            fpa_pkg::OP_ADD: meta_next.simple_res = a + b;
            fpa_pkg::OP_SUB: meta_next.simple_res = a - b;
            fpa_pkg::OP_MUL: meta_next.simple_res = prod[FRAC_BITS+W-1:FRAC_BITS];
            fpa_pkg::OP_MIN: meta_next.simple_res = (a < b) ? a : b;
            fpa_pkg::OP_MAX: meta_next.simple_res = (a > b) ? a : b;
            default:         meta_next.simple_res = '0;
        endcase

        dq_next  = {a_mag, {FRAC_BITS{1'b0}}};
        dvs_next = b_mag;
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            meta_reg <= meta_next;
            dq_reg   <= dq_next;
            dvs_reg  <= dvs_next;
        end
    end

    assign down_valid = valid_reg;
    assign down_meta  = meta_reg;
    assign down_rem   = '0;
    assign down_dq    = dq_reg;
    assign down_dvs   = dvs_reg;

endmodule

`default_nettype wire

### rtl/fpa_div_cell.sv
// One restoring-division step: shifts in one dividend bit, emits one quotient bit.
// Depends on fpa_pkg.
`default_nettype none

module fpa_div_cell #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  up_valid,
    output logic                                 up_ready,
    input  fpa_pkg::meta_t                       up_meta,
    input  wire  [fpa_pkg::DATA_W-1:0]           up_rem,
    input  wire  [fpa_pkg::DATA_W+FRAC_BITS-1:0] up_dq,
    input  wire  [fpa_pkg::DATA_W-1:0]           up_dvs,
    output logic                                 down_valid,
    input  wire                                  down_ready,
    output fpa_pkg::meta_t                       down_meta,
    output logic [fpa_pkg::DATA_W-1:0]           down_rem,
    output logic [fpa_pkg::DATA_W+FRAC_BITS-1:0] down_dq,
    output logic [fpa_pkg::DATA_W-1:0]           down_dvs
);

    localparam int W  = fpa_pkg::DATA_W;
    localparam int DW = W + FRAC_BITS;

    logic           valid_reg;
    fpa_pkg::meta_t meta_reg;
    logic [W-1:0]   rem_reg, rem_next;
    logic [DW-1:0]  dq_reg, dq_next;
    logic [W-1:0]   dvs_reg;

    logic [W:0]     trial, diff;
    logic           take;

    // remainder stays below the divisor, so trial minus divisor fits in W bits
    always_comb
    begin
        trial    = {up_rem, up_dq[DW-1]};
        diff     = trial - {1'b0, up_dvs};
        take     = !diff[W];
        rem_next = take ? diff[W-1:0] : trial[W-1:0];
        dq_next  = {up_dq[DW-2:0], take};
    end

    assign up_ready = !valid_reg || down_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            meta_reg <= up_meta;
            rem_reg  <= rem_next;
            dq_reg   <= dq_next;
            dvs_reg  <= up_dvs;
        end
    end

    assign down_valid = valid_reg;
    assign down_meta  = meta_reg;
    assign down_rem   = rem_reg;
    assign down_dq    = dq_reg;
    assign down_dvs   = dvs_reg;

endmodule

`default_nettype wire

### rtl/fpa_finish.sv
// Output stage: quotient sign fix, result select, response register.
// Depends on fpa_pkg.
`default_nettype none

module fpa_finish #(
    parameter int FRAC_BITS = fpa_pkg::FRAC_BITS_DEF
) (
    input  wire                                  clk,
    input  wire                                  rst_n,
    input  wire                                  up_valid,
    output logic                                 up_ready,
    input  fpa_pkg::meta_t                       up_meta,
    input  wire  [fpa_pkg::DATA_W+FRAC_BITS-1:0] up_dq,
    output logic                                 rsp_valid,
    input  wire                                  rsp_ready,
    output fpa_pkg::rsp_t                        rsp
);

    localparam int W = fpa_pkg::DATA_W;

    logic          valid_reg;
    fpa_pkg::rsp_t rsp_reg, rsp_next;
    logic [W-1:0]  quot, quot_signed;

    always_comb
    begin
        quot        = up_dq[W-1:0];
        quot_signed = up_meta.quot_neg ? (~quot + W'(1)) : quot;

        if (up_meta.kind == fpa_pkg::OP_DIV)
        begin
            rsp_next.result_raw = up_meta.div_zero ? '0 : quot_signed;
        end
        else
        begin
            rsp_next.result_raw = up_meta.simple_res;
        end
        rsp_next.is_less    = up_meta.is_less;
        rsp_next.is_equal   = up_meta.is_equal;
        rsp_next.is_greater = up_meta.is_greater;
        rsp_next.div_zero   = up_meta.div_zero;
    end

    assign up_ready = !valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (up_ready)
        begin
            valid_reg <= up_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (up_ready && up_valid)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

`default_nettype wire

### bench/fixed_point_q24_8_alu_test.sv
// Self-checking bench for the Q24.8 fixed-point ALU: a directed table, then random requests.
// Responses are checked in order against an in-bench predictor.
// Depends on fpa_pkg (request/response types, operation codes) and fixed_point_q24_8_alu.
module fixed_point_q24_8_alu_test;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAC = fpa_pkg::FRAC_BITS_DEF;
    // the block's pipeline depth; used for the settle time at the very end
    localparam int PIPE_DEPTH = FRAC + 34;
    // cycles with no handshake on either side before the run is called hung
    localparam int IDLE_LIMIT = 2000;
    localparam int RANDOM_ITEMS = 400;

    // kind codes the block does not implement; they must return zero
    localparam logic [2:0] OP_UNUSED_6 = 3'd6;
    localparam logic [2:0] OP_UNUSED_7 = 3'd7;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic req_valid = 1'b0;
    logic req_ready;
    fpa_pkg::req_t req = '0;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    fpa_pkg::rsp_t rsp;

    // idle odds in percent, changed per phase
    int send_idle_pct = 22;
    int recv_idle_pct = 62;

    fpa_pkg::rsp_t expected_rsps[$];
    int mismatch_count = 0;
    int quiet_cycles = 0;

    typedef struct {
        fpa_pkg::req_t stim;
        bit            typed;   // 1: want was written by hand, 0: predictor fills it in
        fpa_pkg::rsp_t want;
    } row_t;

    row_t directed_rows[$];

    fixed_point_q24_8_alu uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_ready(req_ready),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_ready(rsp_ready),
        .rsp      (rsp)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: exact 64-bit math, then keep the low 32 bits.
    // ------------------------------------------------------------------
    function automatic fpa_pkg::rsp_t alu_expected(input fpa_pkg::req_t r);
        logic signed [63:0] a;
        logic signed [63:0] b;
        logic signed [63:0] wide;
        fpa_pkg::rsp_t o;
        a = $signed(r.left_raw);
        b = $signed(r.right_raw);
        o = '0;
        case (r.kind)
            fpa_pkg::OP_ADD: o.result_raw = r.left_raw + r.right_raw;
            fpa_pkg::OP_SUB: o.result_raw = r.left_raw - r.right_raw;
            fpa_pkg::OP_MUL:
            begin
                // arithmetic shift: rounds toward minus infinity
                wide = (a * b) >>> FRAC;
                o.result_raw = wide[31:0];
            end
            fpa_pkg::OP_DIV:
            begin
                if (b == 0)
                begin
                    o.div_zero = 1'b1;
                end
                else
                begin
                    // signed divide truncates toward zero; overflow just wraps
                    wide = (a <<< FRAC) / b;
                    o.result_raw = wide[31:0];
                end
            end
            fpa_pkg::OP_MIN: o.result_raw = (a < b) ? r.left_raw : r.right_raw;
            fpa_pkg::OP_MAX: o.result_raw = (a > b) ? r.left_raw : r.right_raw;
            default: o.result_raw = '0;
        endcase
        // flags come from the operands whatever the kind
        o.is_less    = (a < b);
        o.is_equal   = (a == b);
        o.is_greater = (a > b);
        return o;
    endfunction

    // ------------------------------------------------------------------
    // Directed table
    // ------------------------------------------------------------------
    task automatic row_typed(input logic [2:0] k, input logic [31:0] l, input logic [31:0] r,
                             input logic [31:0] res, input bit lt, input bit eq, input bit gt,
                             input bit dz);
        row_t e;
        e.stim  = '{k, l, r};
        e.typed = 1'b1;
        e.want  = '{res, lt, eq, gt, dz};
        directed_rows.push_back(e);
    endtask

    task automatic row_pred(input logic [2:0] k, input logic [31:0] l, input logic [31:0] r);
        row_t e;
        e.stim  = '{k, l, r};
        e.typed = 1'b0;
        e.want  = '0;
        directed_rows.push_back(e);
    endtask

    // ------------------------------------------------------------------
    // Random stimulus helpers
    // ------------------------------------------------------------------
    // Operands lean on the corners: zero, both extremes, small and whole values.
    function automatic logic [31:0] random_operand();
        case ($urandom_range(9))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'(int'($urandom_range(2047)) - 1024);
            4: return 32'((int'($urandom_range(64)) - 32) * 256);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [2:0] random_kind();
        // a few percent land on the unused codes
        if ($urandom_range(99) < 4)
            return ($urandom_range(1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
        case ($urandom_range(5))
            0: return fpa_pkg::OP_ADD;
            1: return fpa_pkg::OP_SUB;
            2: return fpa_pkg::OP_MUL;
            3: return fpa_pkg::OP_DIV;
            4: return fpa_pkg::OP_MIN;
            default: return fpa_pkg::OP_MAX;
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Request driver: called at a falling edge, returns at a falling edge.
    // The expectation is queued at the rising edge that accepts the request.
    // ------------------------------------------------------------------
    task automatic issue_request(input fpa_pkg::req_t r, input fpa_pkg::rsp_t want);
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        expected_rsps.push_back(want);
        @(negedge clk);
    endtask

    // sender holds off until every outstanding response is back
    task automatic wait_for_drain();
        req_valid <= 1'b0;
        while (expected_rsps.size() != 0)
            @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Response side: random back-pressure, changed on the falling edge
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t ns: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    // in-order scoreboard: every response against the oldest expectation
    always @(posedge clk)
    begin : check_rsp
        fpa_pkg::rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (expected_rsps.size() == 0)
            begin
                $display("%0t ns: unexpected response, expected none, got %h", $time, rsp);
                mismatch_count++;
            end
            else
            begin
                want = expected_rsps.pop_front();
                check_field("result_raw", want.result_raw, rsp.result_raw);
                check_field("is_less", want.is_less, rsp.is_less);
                check_field("is_equal", want.is_equal, rsp.is_equal);
                check_field("is_greater", want.is_greater, rsp.is_greater);
                check_field("div_zero", want.div_zero, rsp.div_zero);
            end
        end
    end

    // watchdog: too long with no handshake on either side means a hang
    always @(posedge clk)
    begin
        if (!rst_n || (req_valid && req_ready) || (rsp_valid && rsp_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t ns: no progress for %0d cycles", $time, IDLE_LIMIT);
            $display("CHECK FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin : main_seq
        fpa_pkg::req_t r;
        int per_phase;

        // wrap-around on add and subtract
        row_typed(fpa_pkg::OP_ADD, 32'h7FFF_FFFF, 32'h0000_0001, 32'h8000_0000, 0, 0, 1, 0);
        row_typed(fpa_pkg::OP_ADD, 32'h8000_0000, 32'h8000_0000, 32'h0000_0000, 0, 1, 0, 0);
        row_pred (fpa_pkg::OP_ADD, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        row_typed(fpa_pkg::OP_SUB, 32'h8000_0000, 32'h0000_0001, 32'h7FFF_FFFF, 1, 0, 0, 0);
        row_typed(fpa_pkg::OP_SUB, 32'h0000_0000, 32'h8000_0000, 32'h8000_0000, 0, 0, 1, 0);
        // multiply: 1.0 * 1.0, floor on a negative product, oversized products
        row_typed(fpa_pkg::OP_MUL, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 0, 1, 0, 0);
        row_typed(fpa_pkg::OP_MUL, 32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 1, 0, 0, 0);
        row_pred (fpa_pkg::OP_MUL, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        row_pred (fpa_pkg::OP_MUL, 32'h8000_0000, 32'h8000_0000);
        row_pred (fpa_pkg::OP_MUL, 32'h8000_0000, 32'h0000_0100);
        // divide by zero with each sign of dividend, then 1.0 / 1.0
        row_typed(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0000, 32'h0000_0000, 0, 0, 1, 1);
        row_typed(fpa_pkg::OP_DIV, 32'h8000_0000, 32'h0000_0000, 32'h0000_0000, 1, 0, 0, 1);
        row_typed(fpa_pkg::OP_DIV, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000, 0, 1, 0, 1);
        row_typed(fpa_pkg::OP_DIV, 32'h0000_0100, 32'h0000_0100, 32'h0000_0100, 0, 1, 0, 0);
        // quotient too large to fit, truncation toward zero on both signs
        row_pred (fpa_pkg::OP_DIV, 32'h8000_0000, 32'hFFFF_FFFF);
        row_pred (fpa_pkg::OP_DIV, 32'h7FFF_FFFF, 32'h0000_0001);
        row_pred (fpa_pkg::OP_DIV, 32'hFFFF_FF00, 32'h0000_0300);
        row_pred (fpa_pkg::OP_DIV, 32'h0000_0100, 32'hFFFF_FD00);
        // min and max at the extremes and on equal operands
        row_typed(fpa_pkg::OP_MIN, 32'h0000_0005, 32'h0000_0005, 32'h0000_0005, 0, 1, 0, 0);
        row_typed(fpa_pkg::OP_MAX, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 0, 0, 0);
        row_typed(fpa_pkg::OP_MIN, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1, 0, 0, 0);
        row_pred (fpa_pkg::OP_MAX, 32'hFFFF_FFFD, 32'hFFFF_FFFD);
        // unused kinds give zero but still flag the compare
        row_typed(OP_UNUSED_6, 32'h0000_0001, 32'h0000_0002, 32'h0000_0000, 1, 0, 0, 0);
        row_typed(OP_UNUSED_7, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0000_0000, 0, 0, 1, 0);

        // reset once, released on a falling edge
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed table under the first idle mix
        foreach (directed_rows[i])
            issue_request(directed_rows[i].stim,
                          directed_rows[i].typed ? directed_rows[i].want
                                                 : alu_expected(directed_rows[i].stim));
        wait_for_drain();

        // random phases: sender-light / receiver-heavy, swapped, then no idling
        per_phase = RANDOM_ITEMS / 3;
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_idle_pct = 62;
                end
                1:
                begin
                    send_idle_pct = 62;
                    recv_idle_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                end
            endcase
            for (int n = 0; n < per_phase + ((phase == 0) ? RANDOM_ITEMS % 3 : 0); n++)
            begin
                r.kind      = random_kind();
                r.left_raw  = random_operand();
                // some equal operand pairs so the equal flag and min/max ties show up
                r.right_raw = ($urandom_range(99) < 6) ? r.left_raw : random_operand();
                issue_request(r, alu_expected(r));
            end
            // hold off between phases until the pipe is empty
            wait_for_drain();
        end

        // let any stray response surface before the verdict
        repeat (PIPE_DEPTH + 10) @(negedge clk);
        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### fixed_point_q24_8_alu.f
rtl/fpa_pkg.sv
rtl/fpa_prep.sv
rtl/fpa_div_cell.sv
rtl/fpa_finish.sv
rtl/fixed_point_q24_8_alu.sv
bench/fixed_point_q24_8_alu_test.sv
